@@ sv/jump_table_dispatch_recognizer_defines.svh @@
// Assertion macros for the jump-table dispatch recognizer checker.
// Depends on nothing; included by the checker file.
`ifndef JUMP_TABLE_DISPATCH_RECOGNIZER_DEFINES_SVH
`define JUMP_TABLE_DISPATCH_RECOGNIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define JTDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jtdr checker: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted
`define JTDR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jtdr checker: next-cycle property violated");

`endif

@@ sv/jtdr_pkg.sv @@
// Shared constants for the jump-table dispatch recognizer: PowerPC opcodes,
// register-file sizing and configuration register indexes. No dependencies.
package jtdr_pkg;

	// Register file of the tracked architecture
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int TAG_W     = REG_IDX_W + 1;
	// Register tag with the top bit set means no register recorded
	localparam logic [TAG_W-1:0] NONE_REG = TAG_W'(REG_COUNT);

	// Primary opcodes
	localparam logic [5:0] OP_ADDI   = 6'd14;
	localparam logic [5:0] OP_LIS    = 6'd15;
	localparam logic [5:0] OP_ORI    = 6'd24;
	localparam logic [5:0] OP_EXT    = 6'd31;
	localparam logic [5:0] OP_CMPLWI = 6'd10;
	localparam logic [5:0] OP_CMPWI  = 6'd11;

	// Extended opcodes under primary 31
	localparam logic [9:0] XO_LWZX  = 10'd23;
	localparam logic [9:0] XO_MTSPR = 10'd467;
	localparam logic [9:0] SPR_CTR  = 10'd9;

	// Configuration registers
	localparam int          CFG_DATA_W        = 16;
	localparam logic [0:0]  CFG_DETECT_ENABLE = 1'b0;
	localparam logic [0:0]  CFG_MAX_ENTRIES   = 1'b1;
	localparam logic [15:0] MAX_ENTRIES_RST   = 16'd512;

endpackage

@@ sv/jump_table_dispatch_recognizer.sv @@
// Jump-table dispatch recognizer: decodes one instruction word per transfer.
// A word is held in the input stage, then its result goes to the result register; throughput 1 word
// per cycle when not stalled, set by one pass of decode and register-file update between the stages.
// A last word with a full, stalled result register holds the input stage until it frees.
// Reset (arst_n low, asynchronous) clears all tracking, known bits and valid flags and
// restores detect_enable = 1, max_entries = 512. Depends on jtdr_pkg.
module jump_table_dispatch_recognizer (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [jtdr_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    insn_word,
	input  logic                           in_code,
	input  logic                           last,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           table_found,
	output logic [31:0]                    table_addr,
	output logic [15:0]                    bound_value
);
	import jtdr_pkg::*;

	// configuration
	logic        detect_enable_q;
	logic [15:0] max_entries_q;

	// input stage
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        code_s1;
	logic        last_s1;
	logic [31:0] rda_s1;
	logic [31:0] rdb_s1;

	// tracking state
	logic [31:0]          regs_mem_q [REG_COUNT];
	logic [REG_COUNT-1:0] known_q;
	logic [16:0]          bound_raw_q;
	logic                 bound_seen_q;
	logic [TAG_W-1:0]     load_dest_q;
	logic [TAG_W-1:0]     load_base_a_q;
	logic [TAG_W-1:0]     load_base_b_q;
	logic [TAG_W-1:0]     ctr_source_q;
	logic [31:0]          base_a_val_q;
	logic [31:0]          base_b_val_q;

	// result register
	logic        out_valid_q;
	logic        found_q;
	logic [31:0] base_q;
	logic [15:0] bound_q;

	// handshake
	logic                 accept;
	logic                 advance;
	logic [REG_IDX_W-1:0] rd_addr_a;
	logic [REG_IDX_W-1:0] rd_addr_b;

	// decode
	logic [5:0]           op;
	logic [9:0]           xo;
	logic [REG_IDX_W-1:0] f_rd;
	logic [REG_IDX_W-1:0] f_ra;
	logic [REG_IDX_W-1:0] f_rb;
	logic [15:0]          imm;
	logic [31:0]          simm;
	logic                 is_lis, is_addi, is_ori, is_lwzx, is_mtctr, is_cmp;

	// register-file write from the current word
	logic                 wr_any;
	logic                 wr_known;
	logic [REG_IDX_W-1:0] wr_addr;
	logic [31:0]          wr_data;

	// next tracking state
	logic [REG_COUNT-1:0] known_nxt;
	logic [16:0]          bound_raw_nxt;
	logic                 bound_seen_nxt;
	logic [TAG_W-1:0]     load_dest_nxt, load_base_a_nxt, load_base_b_nxt, ctr_source_nxt;
	logic [31:0]          base_a_val_nxt, base_b_val_nxt;

	// report
	logic        a_ok, b_ok, chain_ok, bound_ok, found_c;
	logic [31:0] base_c;

	// Stall only a last word whose result register is still occupied
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// ori reads its source from the rS field, everything else from rA
	assign rd_addr_a = (insn_word[31:26] == OP_ORI) ? insn_word[25:21] : insn_word[20:16];
	assign rd_addr_b = insn_word[15:11];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_enable_q <= 1'b1;
			max_entries_q   <= MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DETECT_ENABLE: detect_enable_q <= cfg_data[0];
				CFG_MAX_ENTRIES:   max_entries_q   <= cfg_data[15:0];
				default:           ;
			endcase
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= insn_word;
			code_s1 <= in_code;
			last_s1 <= last;
		end
	end

	// Register-value memory: one write, two registered reads, write-first bypass
	always_ff @(posedge clk) begin
		if (advance && wr_any && wr_known) begin
			regs_mem_q[wr_addr] <= wr_data;
		end
		if (accept) begin
			rda_s1 <= (advance && wr_any && wr_known && wr_addr == rd_addr_a) ?
				wr_data : regs_mem_q[rd_addr_a];
			rdb_s1 <= (advance && wr_any && wr_known && wr_addr == rd_addr_b) ?
				wr_data : regs_mem_q[rd_addr_b];
		end
	end

	// Decode the staged word
	always_comb begin
		op       = word_s1[31:26];
		xo       = word_s1[10:1];
		f_rd     = word_s1[25:21];
		f_ra     = word_s1[20:16];
		f_rb     = word_s1[15:11];
		imm      = word_s1[15:0];
		simm     = {{16{imm[15]}}, imm};
		is_lis   = (op == OP_LIS) && (f_ra == '0);
		is_addi  = (op == OP_ADDI);
		is_ori   = (op == OP_ORI);
		is_lwzx  = (op == OP_EXT) && (xo == XO_LWZX);
		is_mtctr = (op == OP_EXT) && (xo == XO_MTSPR) && ({f_rb, f_ra} == SPR_CTR);
		is_cmp   = (op == OP_CMPLWI) || (op == OP_CMPWI);
	end

	// Constant-value update of one register
	always_comb begin
		wr_any   = code_s1 && (is_lis || is_addi || is_ori);
		wr_known = 1'b0;
		wr_addr  = f_rd;
		wr_data  = rda_s1;
		if (is_lis) begin
			wr_known = 1'b1;
			wr_data  = {imm, 16'h0000};
		end else if (is_addi) begin
			wr_known = known_q[f_ra];
			wr_data  = rda_s1 + simm;
		end else if (is_ori) begin
			wr_addr  = f_ra;
			wr_known = known_q[f_rd];
			wr_data  = rda_s1 | {16'h0000, imm};
		end
	end

	// Next tracking state; a word outside code drops everything
	always_comb begin
		known_nxt       = known_q;
		bound_raw_nxt   = bound_raw_q;
		bound_seen_nxt  = bound_seen_q;
		load_dest_nxt   = load_dest_q;
		load_base_a_nxt = load_base_a_q;
		load_base_b_nxt = load_base_b_q;
		ctr_source_nxt  = ctr_source_q;
		base_a_val_nxt  = base_a_val_q;
		base_b_val_nxt  = base_b_val_q;
		if (!code_s1) begin
			known_nxt       = '0;
			bound_raw_nxt   = '0;
			bound_seen_nxt  = 1'b0;
			load_dest_nxt   = NONE_REG;
			load_base_a_nxt = NONE_REG;
			load_base_b_nxt = NONE_REG;
			ctr_source_nxt  = NONE_REG;
		end else begin
			if (wr_any) begin
				known_nxt[wr_addr] = wr_known;
				// keep the recorded load operands' values current
				if (!load_base_a_q[REG_IDX_W] && load_base_a_q[REG_IDX_W-1:0] == wr_addr) begin
					base_a_val_nxt = wr_data;
				end
				if (!load_base_b_q[REG_IDX_W] && load_base_b_q[REG_IDX_W-1:0] == wr_addr) begin
					base_b_val_nxt = wr_data;
				end
			end
			if (is_lwzx) begin
				load_dest_nxt   = {1'b0, f_rd};
				load_base_a_nxt = {1'b0, f_ra};
				load_base_b_nxt = {1'b0, f_rb};
				base_a_val_nxt  = rda_s1;
				base_b_val_nxt  = rdb_s1;
			end
			if (is_mtctr) begin
				ctr_source_nxt = {1'b0, f_rd};
			end
			if (is_cmp) begin
				bound_raw_nxt  = (op == OP_CMPLWI) ? {1'b0, imm} : {imm[15], imm};
				bound_seen_nxt = 1'b1;
			end
		end
	end

	// Chain check on the state after this word
	always_comb begin
		a_ok     = !load_base_a_nxt[REG_IDX_W] && known_nxt[load_base_a_nxt[REG_IDX_W-1:0]];
		b_ok     = !load_base_b_nxt[REG_IDX_W] && known_nxt[load_base_b_nxt[REG_IDX_W-1:0]];
		base_c   = a_ok ? base_a_val_nxt : base_b_val_nxt;
		chain_ok = !ctr_source_nxt[REG_IDX_W] && !load_dest_nxt[REG_IDX_W] &&
			(ctr_source_nxt == load_dest_nxt);
		bound_ok = bound_seen_nxt && !bound_raw_nxt[16] && (bound_raw_nxt != '0) &&
			(bound_raw_nxt[15:0] <= max_entries_q);
		found_c  = detect_enable_q && code_s1 && chain_ok && (a_ok || b_ok) &&
			(base_c != '0) && bound_ok;
	end

	// Commit tracking; a last word or a word outside code opens a new window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q       <= '0;
			bound_raw_q   <= '0;
			bound_seen_q  <= 1'b0;
			load_dest_q   <= NONE_REG;
			load_base_a_q <= NONE_REG;
			load_base_b_q <= NONE_REG;
			ctr_source_q  <= NONE_REG;
		end else if (advance) begin
			if (last_s1 || !code_s1) begin
				known_q       <= '0;
				bound_raw_q   <= '0;
				bound_seen_q  <= 1'b0;
				load_dest_q   <= NONE_REG;
				load_base_a_q <= NONE_REG;
				load_base_b_q <= NONE_REG;
				ctr_source_q  <= NONE_REG;
			end else begin
				known_q       <= known_nxt;
				bound_raw_q   <= bound_raw_nxt;
				bound_seen_q  <= bound_seen_nxt;
				load_dest_q   <= load_dest_nxt;
				load_base_a_q <= load_base_a_nxt;
				load_base_b_q <= load_base_b_nxt;
				ctr_source_q  <= ctr_source_nxt;
			end
		end
	end

	// Shadow values of the load operands; only read while the register is known
	always_ff @(posedge clk) begin
		if (advance) begin
			base_a_val_q <= base_a_val_nxt;
			base_b_val_q <= base_b_val_nxt;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload; fields are zero when no table is found
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			found_q <= found_c;
			base_q  <= found_c ? base_c : '0;
			bound_q <= found_c ? bound_raw_nxt[15:0] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign table_found = found_q;
	assign table_addr  = base_q;
	assign bound_value = bound_q;

endmodule

@@ sv/jtdr_checker.sv @@
// Port-level checker for the jump-table dispatch recognizer, with its bind.
// Depends on jump_table_dispatch_recognizer_defines.svh.
`include "jump_table_dispatch_recognizer_defines.svh"

module jtdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        table_found,
	input logic [31:0] table_addr,
	input logic [15:0] bound_value
);

	// A stalled result transfer holds its payload
	`JTDR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(table_found) && $stable(table_addr) && $stable(bound_value))

	// No table reports zero address and bound
	`JTDR_ASSERT_IMP(a_none_zero, clk, arst_n, out_valid && !table_found, table_addr == 32'd0 && bound_value == 16'd0)

	// A found table has a nonzero base and bound
	`JTDR_ASSERT_IMP(a_found_nonzero, clk, arst_n, out_valid && table_found, table_addr != 32'd0 && bound_value != 16'd0)

endmodule

bind jump_table_dispatch_recognizer jtdr_checker u_jtdr_checker (.*);

@@ tb/sv/dispatch_checker.sv @@
// Checker for the jump-table dispatch recognizer: watches the word and report
// transfers, predicts every dispatch report and compares it field by field.
// Depends on jtdr_pkg.
module dispatch_checker
	import jtdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [31:0]           insn_word,
	input  logic                  in_code,
	input  logic                  last,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  table_found,
	input  logic [31:0]           table_addr,
	input  logic [15:0]           bound_value,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic        found;
		logic [31:0] base;
		logic [15:0] bound;
	} dispatch_report_t;

	// Reports predicted but not yet seen on the result channel
	dispatch_report_t dispatch_reports[$];

	// Constant-propagation state of the current window
	logic [31:0]          const_val [REG_COUNT];
	logic [REG_COUNT-1:0] const_known;
	logic [16:0]          cmp_bound;
	logic                 cmp_seen;
	logic [TAG_W-1:0]     lwzx_dest, lwzx_ra, lwzx_rb, ctr_src;

	// Shadow of the configuration registers
	logic        det_en;
	logic [15:0] max_ent;

	int errors = 0;
	int waiting = 0;

	assign fail_count = errors;
	assign pending    = waiting;

	// Drop everything learned in the current window
	task automatic forget_window();
		foreach (const_val[i])
			const_val[i] = '0;
		const_known = '0;
		cmp_bound   = '0;
		cmp_seen    = 1'b0;
		lwzx_dest   = NONE_REG;
		lwzx_ra     = NONE_REG;
		lwzx_rb     = NONE_REG;
		ctr_src     = NONE_REG;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [5:0]       op;
		logic [9:0]       xo;
		logic [4:0]       rd, ra, rb;
		logic [15:0]      imm;
		logic [31:0]      base;
		logic             have;
		dispatch_report_t want, got;
		if (!arst_n) begin
			det_en  = 1'b1;
			max_ent = MAX_ENTRIES_RST;
			forget_window();
			dispatch_reports.delete();
			waiting = 0;
		end else begin
			// Track configuration writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_DETECT_ENABLE: det_en = cfg_data[0];
					CFG_MAX_ENTRIES:   max_ent = cfg_data[15:0];
				endcase
			end

			// Advance the window on each word transfer
			if (in_valid && in_ready) begin
				op  = insn_word[31:26];
				rd  = insn_word[25:21];
				ra  = insn_word[20:16];
				rb  = insn_word[15:11];
				xo  = insn_word[10:1];
				imm = insn_word[15:0];
				if (!in_code) begin
					forget_window();
				end else if (op == OP_LIS && ra == 5'd0) begin
					const_val[rd]   = {imm, 16'h0000};
					const_known[rd] = 1'b1;
				end else if (op == OP_ADDI) begin
					if (const_known[ra])
						const_val[rd] = const_val[ra] + {{16{imm[15]}}, imm};
					const_known[rd] = const_known[ra];
				end else if (op == OP_ORI) begin
					// ori names its source in the rt slot and its target in rA
					if (const_known[rd])
						const_val[ra] = const_val[rd] | {16'h0000, imm};
					const_known[ra] = const_known[rd];
				end else if (op == OP_EXT && xo == XO_LWZX) begin
					lwzx_dest = {1'b0, rd};
					lwzx_ra   = {1'b0, ra};
					lwzx_rb   = {1'b0, rb};
				end else if (op == OP_EXT && xo == XO_MTSPR && {rb, ra} == SPR_CTR) begin
					ctr_src = {1'b0, rd};
				end else if (op == OP_CMPLWI) begin
					cmp_bound = {1'b0, imm};
					cmp_seen  = 1'b1;
				end else if (op == OP_CMPWI) begin
					cmp_bound = {imm[15], imm};
					cmp_seen  = 1'b1;
				end

				// Predict the report on the dispatch word
				if (last) begin
					want = '0;
					have = 1'b0;
					base = '0;
					if (det_en && in_code && cmp_seen && ctr_src != NONE_REG &&
							lwzx_dest != NONE_REG && ctr_src == lwzx_dest) begin
						if (lwzx_ra != NONE_REG && const_known[lwzx_ra[4:0]]) begin
							base = const_val[lwzx_ra[4:0]];
							have = 1'b1;
						end else if (lwzx_rb != NONE_REG && const_known[lwzx_rb[4:0]]) begin
							base = const_val[lwzx_rb[4:0]];
							have = 1'b1;
						end
						if (have && base != '0 && !cmp_bound[16] &&
								cmp_bound[15:0] != '0 && cmp_bound[15:0] <= max_ent) begin
							want.found = 1'b1;
							want.base  = base;
							want.bound = cmp_bound[15:0];
						end
					end
					dispatch_reports.insert(dispatch_reports.size(), want);
					forget_window();
				end
			end

			// Compare each report transfer with the oldest prediction
			if (out_valid && out_ready) begin
				got = {table_found, table_addr, bound_value};
				if (dispatch_reports.size() == 0) begin
					$error("unexpected report: table_found %0d table_addr %h bound_value %0d",
						table_found, table_addr, bound_value);
					errors++;
				end else begin
					want = dispatch_reports.pop_front();
					if (got.found !== want.found) begin
						$error("table_found: expected %0d, got %0d", want.found, got.found);
						errors++;
					end
					if (got.base !== want.base) begin
						$error("table_addr: expected %h, got %h", want.base, got.base);
						errors++;
					end
					if (got.bound !== want.bound) begin
						$error("bound_value: expected %0d, got %0d", want.bound, got.bound);
						errors++;
					end
				end
			end
			waiting = dispatch_reports.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the jump-table dispatch recognizer testbench: clock, reset, register
// writes, instruction-window stimulus with bursts and stalls, and the verdict.
// Depends on jtdr_pkg, the recognizer and dispatch_checker.
module testbench;
	import jtdr_pkg::*;

	localparam logic [31:0] BCTR_WORD = 32'h4E80_0420;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [0:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [31:0]           insn_word = '0;
	logic                  in_code = 1'b0;
	logic                  last = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  table_found;
	logic [31:0]           table_addr;
	logic [15:0]           bound_value;
	int                    fail_count;
	int                    pending;

	int          words_sent = 0;
	int          burst_left = 0;
	logic        gaps_on = 1'b1;
	logic [11:0] stall_pat = '1;
	int          stall_tick = 0;

	jump_table_dispatch_recognizer dut (.*);

	dispatch_checker u_checker (.*);

	always #1 clk = ~clk;

	// Stall the result channel on a rotating pattern, reshuffled now and then
	always @(posedge clk) begin
		if (stall_tick == 0) begin
			stall_tick = $urandom_range(16, 96);
			case ($urandom_range(0, 3))
				0:       stall_pat = '1;
				1:       stall_pat = 12'h001;
				2:       stall_pat = 12'($urandom) | 12'h111;
				default: stall_pat = 12'($urandom) | 12'h001;
			endcase
		end
		stall_tick--;
		stall_pat = {stall_pat[0], stall_pat[11:1]};
		out_ready <= stall_pat[0];
	end

	function automatic logic [31:0] d_form(logic [5:0] op, logic [4:0] rt, logic [4:0] ra,
			logic [15:0] imm);
		return {op, rt, ra, imm};
	endfunction

	function automatic logic [31:0] x_form(logic [5:0] op, logic [4:0] rt, logic [4:0] ra,
			logic [4:0] rb, logic [9:0] xo, logic rc);
		return {op, rt, ra, rb, xo, rc};
	endfunction

	// Offer one word and hold it until the transfer; idle between bursts
	task automatic send_word(input logic [31:0] w, input logic code, input logic fin);
		if (gaps_on && burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid  <= 1'b1;
		insn_word <= w;
		in_code   <= code;
		last      <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	// Stop offering words and wait until every report has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One dispatch window: table base, compare, indexed load, mtctr, bctr,
	// with filler words and occasional breaks in the chain
	task automatic send_window(input logic [15:0] max_now);
		logic [31:0] seq[$];
		logic [4:0]  tab_reg, base_reg, idx_reg, val_reg, ctr_reg;
		logic [15:0] hi, lo, bnd;
		logic [5:0]  cmp_op;
		logic [31:0] w;
		int          dead_at;
		tab_reg  = 5'($urandom);
		idx_reg  = 5'($urandom);
		val_reg  = 5'($urandom);
		hi       = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
		lo       = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
		base_reg = tab_reg;

		// Build the table address
		seq.insert(seq.size(), d_form(OP_LIS, tab_reg, 5'd0, hi));
		case ($urandom_range(0, 4))
			0: seq.insert(seq.size(), d_form(OP_ADDI, tab_reg, tab_reg, lo));
			1: seq.insert(seq.size(), d_form(OP_ORI, tab_reg, tab_reg, lo));
			2: begin
				base_reg = 5'($urandom);
				seq.insert(seq.size(), d_form(OP_ORI, tab_reg, base_reg, lo));
			end
			3: begin
				// source is sometimes a register with no known value
				base_reg = 5'($urandom);
				seq.insert(seq.size(), d_form(OP_ADDI, base_reg,
					($urandom_range(0, 2) == 0) ? idx_reg : tab_reg, lo));
			end
			default: ;
		endcase

		// Indexed load with the base in either operand, then mtctr
		if ($urandom_range(0, 1) != 0)
			seq.insert(seq.size(),
				x_form(OP_EXT, val_reg, base_reg, idx_reg, XO_LWZX, 1'($urandom)));
		else
			seq.insert(seq.size(),
				x_form(OP_EXT, val_reg, idx_reg, base_reg, XO_LWZX, 1'($urandom)));
		ctr_reg = ($urandom_range(0, 7) == 0) ? 5'($urandom) : val_reg;
		seq.insert(seq.size(),
			x_form(OP_EXT, ctr_reg, SPR_CTR[4:0], SPR_CTR[9:5], XO_MTSPR, 1'b0));

		// Bound compare, placed anywhere in the window
		case ($urandom_range(0, 11))
			0:       bnd = 16'd0;
			1:       bnd = max_now;
			2:       bnd = max_now + 16'd1;
			3:       bnd = 16'hFFFF;
			4:       bnd = 16'($urandom_range(32'h8000, 32'hFFFF));
			default: bnd = 16'($urandom_range(1, max_now));
		endcase
		cmp_op = ($urandom_range(0, 1) != 0) ? OP_CMPLWI : OP_CMPWI;
		if ($urandom_range(0, 15) != 0)
			seq.insert($urandom_range(0, seq.size()), d_form(cmp_op, 5'($urandom), idx_reg, bnd));

		// Unrelated words between the chain steps
		repeat ($urandom_range(0, 3)) begin
			do
				w = $urandom;
			while (w[31:26] == OP_LIS || w[31:26] == OP_ADDI || w[31:26] == OP_ORI ||
				w[31:26] == OP_EXT || w[31:26] == OP_CMPLWI || w[31:26] == OP_CMPWI);
			seq.insert($urandom_range(0, seq.size()), w);
		end
		if ($urandom_range(0, 9) == 0)
			seq.insert($urandom_range(0, seq.size()), $urandom);
		if ($urandom_range(0, 7) != 0)
			seq.insert(seq.size(), BCTR_WORD);

		dead_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, seq.size() - 1) : -1;
		foreach (seq[i])
			send_word(seq[i], i != dead_at, i == seq.size() - 1);
	endtask

	// Loose word, biased toward the decoded opcodes
	task automatic send_noise();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 7))
			0: w[31:26] = OP_LIS;
			1: w[31:26] = OP_ADDI;
			2: w[31:26] = OP_ORI;
			3: begin
				w[31:26] = OP_EXT;
				w[10:1]  = XO_LWZX;
			end
			4: begin
				w[31:26] = OP_EXT;
				w[10:1]  = XO_MTSPR;
				if ($urandom_range(0, 1) != 0)
					w[20:11] = {SPR_CTR[4:0], SPR_CTR[9:5]};
			end
			5: w[31:26] = ($urandom_range(0, 1) != 0) ? OP_CMPLWI : OP_CMPWI;
			default: ;
		endcase
		send_word(w, $urandom_range(0, 7) != 0, $urandom_range(0, 5) == 0);
	endtask

	initial begin
		int          target;
		logic        en_now;
		logic [15:0] max_now;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone dispatch words at both extremes of the word
		send_word(32'h0000_0000, 1'b1, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
		// Complete chain: lis/ori base, cmplwi bound 1, base in rA
		send_word(d_form(OP_LIS, 5'd5, 5'd0, 16'h8000), 1'b1, 1'b0);
		send_word(d_form(OP_ORI, 5'd5, 5'd5, 16'h1230), 1'b1, 1'b0);
		send_word(d_form(OP_CMPLWI, 5'd0, 5'd4, 16'd1), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd6, 5'd5, 5'd4, XO_LWZX, 1'b0), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd6, SPR_CTR[4:0], SPR_CTR[9:5], XO_MTSPR, 1'b0), 1'b1, 1'b0);
		send_word(BCTR_WORD, 1'b1, 1'b1);
		// Negative cmpwi bound, base in rB, window ending on mtctr
		send_word(d_form(OP_LIS, 5'd5, 5'd0, 16'h8040), 1'b1, 1'b0);
		send_word(d_form(OP_ADDI, 5'd5, 5'd5, 16'hFFFC), 1'b1, 1'b0);
		send_word(d_form(OP_CMPWI, 5'd0, 5'd4, 16'hFFFF), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd7, 5'd4, 5'd5, XO_LWZX, 1'b1), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd7, SPR_CTR[4:0], SPR_CTR[9:5], XO_MTSPR, 1'b0), 1'b1, 1'b1);
		// Zero base with the bound at the maximum
		send_word(d_form(OP_LIS, 5'd9, 5'd0, 16'h0000), 1'b1, 1'b0);
		send_word(d_form(OP_CMPLWI, 5'd0, 5'd3, 16'd512), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd3, 5'd9, 5'd9, XO_LWZX, 1'b0), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd3, SPR_CTR[4:0], SPR_CTR[9:5], XO_MTSPR, 1'b0), 1'b1, 1'b0);
		send_word(BCTR_WORD, 1'b1, 1'b1);
		// Base from addi on a register with no known value
		send_word(d_form(OP_ADDI, 5'd8, 5'd2, 16'h0010), 1'b1, 1'b0);
		send_word(d_form(OP_CMPLWI, 5'd0, 5'd3, 16'd2), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd4, 5'd8, 5'd8, XO_LWZX, 1'b0), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd4, SPR_CTR[4:0], SPR_CTR[9:5], XO_MTSPR, 1'b0), 1'b1, 1'b1);
		// Good chain whose dispatch word lies outside code
		send_word(d_form(OP_LIS, 5'd31, 5'd0, 16'hFFFF), 1'b1, 1'b0);
		send_word(d_form(OP_CMPLWI, 5'd0, 5'd0, 16'd512), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd0, 5'd31, 5'd0, XO_LWZX, 1'b0), 1'b1, 1'b0);
		send_word(x_form(OP_EXT, 5'd0, SPR_CTR[4:0], SPR_CTR[9:5], XO_MTSPR, 1'b0), 1'b1, 1'b0);
		send_word(BCTR_WORD, 1'b0, 1'b1);
		drain();

		// Random windows under several register settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       begin en_now = 1'b1; max_now = 16'hFFFF; end
				1:       begin en_now = 1'b1; max_now = 16'd1;    end
				2:       begin en_now = 1'b0; max_now = 16'd512;  end
				3:       begin en_now = 1'b1; max_now = 16'd16;   end
				4:       begin en_now = 1'b1; max_now = 16'd512;  end
				default: begin en_now = 1'b0; max_now = 16'hFFFF; end
			endcase
			write_reg(CFG_DETECT_ENABLE, CFG_DATA_W'(en_now));
			write_reg(CFG_MAX_ENTRIES, max_now);
			gaps_on = (phase != 4);
			target  = words_sent + 280;
			while (words_sent < target) begin
				if ($urandom_range(0, 4) != 0)
					send_window(max_now);
				else
					send_noise();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[jump_table_dispatch_recognizer] OK");
		else
			$display("[jump_table_dispatch_recognizer] ERROR");
		$finish;
	end

	// End a hung run
	initial begin
		#1000000;
		$display("[jump_table_dispatch_recognizer] ERROR");
		$finish;
	end

endmodule
